@@ src/lcfc_pkg.sv @@
// Package for the length-prefixed CRC-32 frame checker.
// Holds verdict codes, phase codes, result word type and the byte-wide CRC step.
// Depends on nothing.
`default_nettype none

package lcfc_pkg;

  // Reflected CRC-32 polynomial, init value and register reset value
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

  // Header is 8 bytes: length (LE) then CRC (LE)
  localparam int unsigned HDR_BYTES = 8;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_MISMATCH = 2'd1,
    VERDICT_TOO_LONG = 2'd2
  } verdict_t;

  typedef enum logic {
    PH_HEADER = 1'b0,
    PH_BODY   = 1'b1
  } phase_t;

  // One result word as held in the output stage
  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] body_length;
    logic [31:0] expected_crc;
    logic [31:0] computed_crc;
  } result_t;

  // One byte of reflected CRC-32, eight unrolled bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/length_crc_frame_checker.sv @@
// Top level of the length-prefixed CRC-32 frame checker.
// Uses lcfc_pkg for codes, the result word type and the CRC byte step.
//
// Usage:
//   Input channel (in_valid/in_ready/data_byte) carries the byte stream: each
//   message is an 8-byte header (32-bit LE body length, 32-bit LE CRC-32) then
//   the body. Output channel (out_valid/out_ready) carries one word per
//   message: verdict, body_length, expected_crc, computed_crc.
//   A header whose length exceeds max_length gives a too-long verdict on its
//   last byte and the next byte starts a new header. A zero-length body gives
//   its verdict on the last header byte.
//   max_length is written through cfg_write_en/cfg_write_data, no wait state.
// Throughput: one byte per cycle while in_ready is high; the CRC of a byte is
//   one unrolled step between the state registers.
// Output: each result word is registered into the output stage on its last byte.
// Stall: a two-word output stage (result register plus skid register) lets
//   the input keep flowing while one word waits; in_ready drops only when
//   both are full.
// Reset: rst (synchronous) returns to the header phase, empties the output
//   stage and sets max_length to 1048576.
`default_nettype none

module length_crc_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       verdict,
  output logic [31:0]      body_length,
  output logic [31:0]      expected_crc,
  output logic [31:0]      computed_crc,
  input  wire logic        cfg_write_en,
  input  wire logic [31:0] cfg_write_data
);

  logic [31:0]       max_length;
  lcfc_pkg::phase_t  phase, phase_next;
  logic [31:0]       byte_count, byte_count_next;
  logic [63:0]       header_bits, header_bits_next;
  logic [31:0]       crc_register, crc_register_next;

  logic              accept;
  logic              res_fire;
  lcfc_pkg::result_t res;

  logic              head_valid, skid_valid;
  lcfc_pkg::result_t head, skid;
  logic              pop;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= lcfc_pkg::MAX_LEN_RESET;
    end else if (cfg_write_en) begin
      max_length <= cfg_write_data;
    end
  end

  // Per-byte framing and CRC update
  always_comb begin
    logic [2:0]  idx;
    logic [31:0] len;
    logic [31:0] exp_crc;
    logic [31:0] crc_upd;
    logic [31:0] cnt1;
    phase_next        = phase;
    byte_count_next   = byte_count;
    header_bits_next  = header_bits;
    crc_register_next = crc_register;
    res_fire          = 1'b0;
    res               = '0;
    idx               = byte_count[2:0];
    len               = header_bits[31:0];
    exp_crc           = header_bits[63:32];
    crc_upd           = lcfc_pkg::crc_byte(crc_register, data_byte);
    cnt1              = byte_count + 32'd1;
    if (accept) begin
      if (phase == lcfc_pkg::PH_HEADER) begin
        header_bits_next[{idx, 3'b000} +: 8] = data_byte;
        len     = header_bits_next[31:0];
        exp_crc = header_bits_next[63:32];
        if (idx == 3'(lcfc_pkg::HDR_BYTES - 1)) begin
          byte_count_next   = '0;
          crc_register_next = lcfc_pkg::CRC_INIT;
          res.body_length   = len;
          res.expected_crc  = exp_crc;
          res.computed_crc  = '0;
          if (len > max_length) begin
            res_fire    = 1'b1;
            res.verdict = lcfc_pkg::VERDICT_TOO_LONG;
          end else if (len == 32'd0) begin
            // empty body: CRC of the empty string is zero
            res_fire    = 1'b1;
            res.verdict = (exp_crc == 32'd0) ? lcfc_pkg::VERDICT_OK
                                             : lcfc_pkg::VERDICT_MISMATCH;
          end else begin
            phase_next = lcfc_pkg::PH_BODY;
          end
        end else begin
          byte_count_next = {29'd0, idx} + 32'd1;
        end
      end else begin
        if (cnt1 < len) begin
          byte_count_next   = cnt1;
          crc_register_next = crc_upd;
        end else begin
          // last body byte
          res_fire          = 1'b1;
          res.body_length   = len;
          res.expected_crc  = exp_crc;
          res.computed_crc  = ~crc_upd;
          res.verdict       = (~crc_upd == exp_crc) ? lcfc_pkg::VERDICT_OK
                                                    : lcfc_pkg::VERDICT_MISMATCH;
          phase_next        = lcfc_pkg::PH_HEADER;
          byte_count_next   = '0;
          crc_register_next = lcfc_pkg::CRC_INIT;
        end
      end
    end
  end

  // Framing state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lcfc_pkg::PH_HEADER;
      byte_count   <= '0;
      header_bits  <= '0;
      crc_register <= lcfc_pkg::CRC_INIT;
    end else begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      header_bits  <= header_bits_next;
      crc_register <= crc_register_next;
    end
  end

  // Output stage: head register plus skid register
  assign pop = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= res_fire;
      end
    end else if (!head_valid) begin
      head_valid <= res_fire;
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
      end else begin
        head <= res;
      end
    end else if (!head_valid) begin
      head <= res;
    end else if (res_fire) begin
      skid <= res;
    end
  end

  assign out_valid    = head_valid;
  assign verdict      = head.verdict;
  assign body_length  = head.body_length;
  assign expected_crc = head.expected_crc;
  assign computed_crc = head.computed_crc;

endmodule

`default_nettype wire

@@ src/lcfc_checker.sv @@
// Port-level checker for length_crc_frame_checker, bound to the top level.
// Uses lcfc_pkg for verdict codes.
`default_nettype none

module lcfc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  verdict,
  input wire logic [31:0] body_length,
  input wire logic [31:0] expected_crc,
  input wire logic [31:0] computed_crc
);

  // A stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(body_length)
      && $stable(expected_crc) && $stable(computed_crc))
    else $error("output word changed while stalled");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict == lcfc_pkg::VERDICT_OK || verdict == lcfc_pkg::VERDICT_MISMATCH
      || verdict == lcfc_pkg::VERDICT_TOO_LONG)
    else $error("undefined verdict code");

  // Too-long frames carry no computed CRC
  a_too_long_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == lcfc_pkg::VERDICT_TOO_LONG |-> computed_crc == 32'd0)
    else $error("too-long verdict with nonzero computed CRC");

  // OK means the CRCs agree
  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == lcfc_pkg::VERDICT_OK |-> computed_crc == expected_crc)
    else $error("ok verdict with differing CRCs");

  // Mismatch means the CRCs differ
  a_mismatch_differs: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == lcfc_pkg::VERDICT_MISMATCH |-> computed_crc != expected_crc)
    else $error("mismatch verdict with equal CRCs");

endmodule

bind length_crc_frame_checker lcfc_checker u_lcfc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .verdict      (verdict),
  .body_length  (body_length),
  .expected_crc (expected_crc),
  .computed_crc (computed_crc)
);

`default_nettype wire
